@@ hdl/block_slope_pulse_rate_detector_assert.svh @@
// assertion macros for the slope pulse-rate detector
// used by the top level only, no other dependencies
`ifndef BLOCK_SLOPE_PULSE_RATE_DETECTOR_ASSERT_SVH
`define BLOCK_SLOPE_PULSE_RATE_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/spr_pkg.sv @@
// shared constants, register codes and types of the slope pulse-rate detector
// no dependencies
`timescale 1ns / 1ps

package spr_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int COUNT_W  = 16;
    localparam int TIMER_W  = 16;
    localparam int BPM_W    = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
    localparam logic [BPM_W-1:0]   BPM_NUMERATOR = 16'd60000;

    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INVERT       = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd3;

    localparam logic [COUNT_W-1:0] BLOCK_SIZE_RST   = 16'd5000;
    localparam int                 THRESHOLD_RST    = 9530;
    localparam logic [TIMER_W-1:0] MIN_INTERVAL_RST = 16'd200;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hdl/spr_cfg.sv @@
// configuration register file with the apb-style port
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_cfg #(
    parameter int SLOPE_W = spr_pkg::SAMPLE_BITS_DEF + spr_pkg::FRACTION_BITS_DEF + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spr_pkg::ADDR_W-1:0]    paddr,
    input  logic [spr_pkg::DATA_W-1:0]    pwdata,
    output logic [spr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [spr_pkg::COUNT_W-1:0]   block_size,
    output logic signed [SLOPE_W-1:0]     slope_threshold,
    output logic                          invert_sample,
    output logic [spr_pkg::TIMER_W-1:0]   min_interval
);
    import spr_pkg::*;

    logic [COUNT_W-1:0]   block_size_reg;
    logic [SLOPE_W-1:0]   threshold_reg;
    logic                 invert_reg;
    logic [TIMER_W-1:0]   min_interval_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg   <= BLOCK_SIZE_RST;
            threshold_reg    <= SLOPE_W'(THRESHOLD_RST);
            invert_reg       <= 1'b0;
            min_interval_reg <= MIN_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_BLOCK_SIZE:   block_size_reg   <= pwdata[COUNT_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= pwdata[SLOPE_W-1:0];
                REG_INVERT:       invert_reg       <= pwdata[0];
                REG_MIN_INTERVAL: min_interval_reg <= pwdata[TIMER_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BLOCK_SIZE:   prdata = DATA_W'(block_size_reg);
            REG_THRESHOLD:    prdata = DATA_W'($signed(threshold_reg));
            REG_INVERT:       prdata = DATA_W'(invert_reg);
            REG_MIN_INTERVAL: prdata = DATA_W'(min_interval_reg);
            default:          prdata = '0;
        endcase
    end

    assign block_size      = block_size_reg;
    assign slope_threshold = $signed(threshold_reg);
    assign invert_sample   = invert_reg;
    assign min_interval    = min_interval_reg;

endmodule

@@ hdl/spr_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_div #(
    parameter  int QUO_W  = spr_pkg::SAMPLE_BITS_DEF + spr_pkg::FRACTION_BITS_DEF,
    localparam int STEP_W = $clog2(QUO_W + 1),
    localparam int DSR_W  = spr_pkg::COUNT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DSR_W-1:0]    rem_init,
    input  logic [QUO_W-1:0]    quo_init,
    input  logic [DSR_W-1:0]    divisor,
    input  logic [STEP_W-1:0]   steps,
    output logic [QUO_W-1:0]    quotient,
    output spr_pkg::div_stat_t  stat
);
    import spr_pkg::*;

    logic [DSR_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    trial;
    logic              fits;
    logic              last_step;

    // shift in the next dividend bit and try the subtract
    assign shifted   = {rem_reg, quo_reg[QUO_W-1]};
    assign trial     = shifted - {1'b0, dsr_reg};
    assign fits      = !trial[DSR_W];
    assign last_step = busy_reg && (cnt_reg == STEP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= quo_init;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/spr_core.sv @@
// block accumulation, sequencer and result registers of the detector
// depends on spr_pkg, drives the shared divider spr_div
`timescale 1ns / 1ps

module spr_core #(
    parameter  int SAMPLE_BITS   = spr_pkg::SAMPLE_BITS_DEF,
    parameter  int FRACTION_BITS = spr_pkg::FRACTION_BITS_DEF,
    localparam int MEAN_W  = SAMPLE_BITS + FRACTION_BITS,
    localparam int QUO_W   = (MEAN_W > spr_pkg::BPM_W) ? MEAN_W : spr_pkg::BPM_W,
    localparam int STEP_W  = $clog2(QUO_W + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [SAMPLE_BITS-1:0]        sample_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [MEAN_W-1:0]             block_mean,
    output logic signed [MEAN_W:0]        slope,
    output logic                          over_threshold,
    output logic                          beat_accepted,
    output logic [spr_pkg::TIMER_W-1:0]   interval_ms,
    output logic [spr_pkg::BPM_W-1:0]     bpm,
    input  logic [spr_pkg::COUNT_W-1:0]   block_size,
    input  logic signed [MEAN_W:0]        slope_threshold,
    input  logic                          invert_sample,
    input  logic [spr_pkg::TIMER_W-1:0]   min_interval,
    output logic                          div_start,
    output logic [spr_pkg::COUNT_W-1:0]   div_rem_init,
    output logic [QUO_W-1:0]              div_quo_init,
    output logic [spr_pkg::COUNT_W-1:0]   div_divisor,
    output logic [STEP_W-1:0]             div_steps,
    input  logic [QUO_W-1:0]              div_quotient,
    input  spr_pkg::div_stat_t            div_stat
);
    import spr_pkg::*;

    localparam int SLOPE_W = MEAN_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
    localparam int DVD_W   = SUM_W + FRACTION_BITS;
    localparam logic [SAMPLE_BITS-1:0] CODE_MAX = '1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_MEAN = 3'd1;
    localparam logic [2:0] ST_EVAL     = 3'd2;
    localparam logic [2:0] ST_DIV_BPM  = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [MEAN_W-1:0]   prev_reg, prev_next;
    logic [MEAN_W-1:0]   mean_reg, mean_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [TIMER_W-1:0]  held_int_reg, held_int_next;
    logic [BPM_W-1:0]    held_bpm_reg, held_bpm_next;
    logic [SLOPE_W-1:0]  slope_reg, slope_next;
    logic                over_reg, over_next;
    logic                acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic                div_for_bpm;

    logic [MEAN_W-1:0]   block_mean_reg;
    logic [SLOPE_W-1:0]  slope_out_reg;
    logic                over_out_reg;
    logic                acc_out_reg;
    logic [TIMER_W-1:0]  interval_out_reg;
    logic [BPM_W-1:0]    bpm_out_reg;

    logic [SAMPLE_BITS-1:0] code;
    logic [SUM_W-1:0]       sum_add;
    logic [COUNT_W-1:0]     cnt_inc;
    logic [COUNT_W-1:0]     size_eff;
    logic [COUNT_W-1:0]     div_count;
    logic                   finish;
    logic [DVD_W-1:0]       dividend;
    logic signed [SLOPE_W-1:0] slope_calc;
    logic                   over_calc;

    assign code      = invert_sample ? (CODE_MAX - sample_code) : sample_code;
    assign sum_add   = sum_reg + SUM_W'(code);
    assign cnt_inc   = cnt_reg + COUNT_W'(1);
    assign size_eff  = (block_size == '0) ? COUNT_W'(1) : block_size;
    // a wrapped count closes the block too and divides by one
    assign finish    = (cnt_inc >= size_eff) || (cnt_inc == '0);
    assign div_count = (cnt_inc == '0) ? COUNT_W'(1) : cnt_inc;
    // round half up: add half the count before dividing
    assign dividend  = (DVD_W'(sum_add) << FRACTION_BITS) + DVD_W'(div_count >> 1);

    assign slope_calc = $signed(SLOPE_W'({1'b0, mean_reg})) - $signed(SLOPE_W'({1'b0, prev_reg}));
    assign over_calc  = slope_calc > slope_threshold;

    // the quotient fits in MEAN_W bits, so the top of the dividend is already below the count
    assign div_rem_init = div_for_bpm ? '0 : dividend[DVD_W-1:MEAN_W];
    assign div_quo_init = div_for_bpm ? (QUO_W'(BPM_NUMERATOR) << (QUO_W - BPM_W))
                                      : (QUO_W'(dividend[MEAN_W-1:0]) << (QUO_W - MEAN_W));
    assign div_divisor  = div_for_bpm ? timer_reg : div_count;
    assign div_steps    = div_for_bpm ? STEP_W'(BPM_W) : STEP_W'(MEAN_W);

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        mean_next      = mean_reg;
        timer_next     = timer_reg;
        held_int_next  = held_int_reg;
        held_bpm_next  = held_bpm_reg;
        slope_next     = slope_reg;
        over_next      = over_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        div_start      = 1'b0;
        div_for_bpm    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation)
                    begin
                        if (timer_reg != TIMER_MAX)
                        begin
                            timer_next = timer_reg + TIMER_W'(1);
                        end
                    end
                    else if (finish)
                    begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV_MEAN;
                    end
                    else
                    begin
                        sum_next = sum_add;
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_DIV_MEAN:
            begin
                if (div_stat.done)
                begin
                    mean_next  = div_quotient[MEAN_W-1:0];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                slope_next = slope_calc;
                over_next  = over_calc;
                prev_next  = mean_reg;
                acc_next   = 1'b0;
                state_next = ST_EMIT;
                if (over_calc)
                begin
                    // every candidate restarts the timer, accepted or not
                    timer_next = '0;
                    if (timer_reg >= min_interval)
                    begin
                        acc_next      = 1'b1;
                        held_int_next = timer_reg;
                        if (timer_reg == '0)
                        begin
                            held_bpm_next = '0;
                        end
                        else
                        begin
                            div_start   = 1'b1;
                            div_for_bpm = 1'b1;
                            state_next  = ST_DIV_BPM;
                        end
                    end
                end
            end
            ST_DIV_BPM:
            begin
                div_for_bpm = 1'b1;
                if (div_stat.done)
                begin
                    held_bpm_next = div_quotient[BPM_W-1:0];
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            timer_reg     <= '0;
            held_int_reg  <= '0;
            held_bpm_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            timer_reg     <= timer_next;
            held_int_reg  <= held_int_next;
            held_bpm_reg  <= held_bpm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg  <= mean_next;
        slope_reg <= slope_next;
        over_reg  <= over_next;
        acc_reg   <= acc_next;
        if (out_load)
        begin
            block_mean_reg   <= mean_reg;
            slope_out_reg    <= slope_reg;
            over_out_reg     <= over_reg;
            acc_out_reg      <= acc_reg;
            interval_out_reg <= held_int_reg;
            bpm_out_reg      <= held_bpm_reg;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign block_mean     = block_mean_reg;
    assign slope          = $signed(slope_out_reg);
    assign over_threshold = over_out_reg;
    assign beat_accepted  = acc_out_reg;
    assign interval_ms    = interval_out_reg;
    assign bpm            = bpm_out_reg;

endmodule

@@ hdl/block_slope_pulse_rate_detector.sv @@
// Slope pulse-rate detector, top level.
// Input channel (in_valid / in_stall): one transaction is either an adc sample
// (operation 0, sample_code) or a one-millisecond tick (operation 1).
// Output channel (out_valid / out_stall): one transaction per finished block with
// block_mean (Q.FRACTION_BITS), slope against the previous mean, over_threshold,
// beat_accepted and the held interval_ms and bpm of the last accepted beat.
// Timing: a tick or a sample that does not close a block leaves in_stall low, so the
// next transaction is taken in the following cycle. A sample that closes a block
// holds in_stall for the mean division, one bit per cycle in the shared divider,
// then the quotient capture, the evaluate step and the emit step, plus the bpm
// division and its quotient capture when a beat is accepted with a nonzero interval;
// out_valid is set and in_stall drops at the same edge.
// The result sits in an output register; if the receiver stalls, a closing
// sample waits in the emit step until that register frees, other inputs are
// still taken while nothing new needs it.
// Reset clears sums, counters, the timer, held values and out_valid; the
// registers return to block size 5000, threshold 9530, no invert, 200 ms.
// Registers sit at byte addresses 0, 4, 8, 12 on the apb port; pready is tied high.
// depends on spr_pkg, spr_cfg, spr_div, spr_core and the assertion macro header
`timescale 1ns / 1ps
`include "block_slope_pulse_rate_detector_assert.svh"

module block_slope_pulse_rate_detector #(
    parameter  int SAMPLE_BITS   = spr_pkg::SAMPLE_BITS_DEF,
    parameter  int FRACTION_BITS = spr_pkg::FRACTION_BITS_DEF,
    localparam int MEAN_W = SAMPLE_BITS + FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [SAMPLE_BITS-1:0]        sample_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [MEAN_W-1:0]             block_mean,
    output logic signed [MEAN_W:0]        slope,
    output logic                          over_threshold,
    output logic                          beat_accepted,
    output logic [spr_pkg::TIMER_W-1:0]   interval_ms,
    output logic [spr_pkg::BPM_W-1:0]     bpm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spr_pkg::ADDR_W-1:0]    paddr,
    input  logic [spr_pkg::DATA_W-1:0]    pwdata,
    output logic [spr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import spr_pkg::*;

    localparam int QUO_W  = (MEAN_W > BPM_W) ? MEAN_W : BPM_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [COUNT_W-1:0]       block_size;
    logic signed [MEAN_W:0]   slope_threshold;
    logic                     invert_sample;
    logic [TIMER_W-1:0]       min_interval;
    logic                     div_start;
    logic [COUNT_W-1:0]       div_rem_init;
    logic [QUO_W-1:0]         div_quo_init;
    logic [COUNT_W-1:0]       div_divisor;
    logic [STEP_W-1:0]        div_steps;
    logic [QUO_W-1:0]         div_quotient;
    div_stat_t                div_stat;

    spr_cfg #(
        .SLOPE_W (MEAN_W + 1)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .block_size      (block_size),
        .slope_threshold (slope_threshold),
        .invert_sample   (invert_sample),
        .min_interval    (min_interval)
    );

    spr_div #(
        .QUO_W (QUO_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .quo_init (div_quo_init),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    spr_core #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .sample_code     (sample_code),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .block_mean      (block_mean),
        .slope           (slope),
        .over_threshold  (over_threshold),
        .beat_accepted   (beat_accepted),
        .interval_ms     (interval_ms),
        .bpm             (bpm),
        .block_size      (block_size),
        .slope_threshold (slope_threshold),
        .invert_sample   (invert_sample),
        .min_interval    (min_interval),
        .div_start       (div_start),
        .div_rem_init    (div_rem_init),
        .div_quo_init    (div_quo_init),
        .div_divisor     (div_divisor),
        .div_steps       (div_steps),
        .div_quotient    (div_quotient),
        .div_stat        (div_stat)
    );

    // divider only runs while the input side is held off
    `SPR_ASSERT_IMP(a_div_busy_stalls, clk, rst_n, div_stat.busy, in_stall, "divider busy while input open")
    // a tick transaction never produces a result
    `SPR_ASSERT_NXT(a_tick_no_result, clk, rst_n, in_valid && !in_stall && operation, !$rose(out_valid), "result after tick")
    // a new result only comes out of a busy sequence
    `SPR_ASSERT_IMP(a_result_after_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result without block work")
    // an accepted beat is always a candidate
    `SPR_ASSERT_IMP(a_beat_is_candidate, clk, rst_n, out_valid && beat_accepted, over_threshold, "beat without candidate")

endmodule

@@ sim/block_slope_pulse_rate_detector_tb.sv @@
// testbench for the slope pulse-rate detector: directed and random transactions,
// checked field by field against a scoreboard that predicts every block result
// depends on spr_pkg and the block_slope_pulse_rate_detector top level
`timescale 1ns / 1ps

module block_slope_pulse_rate_detector_tb;

    import spr_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam int MW = SB + FB;
    localparam int SUM_W = SB + COUNT_W;

    localparam logic [SB-1:0] CODE_MAX = '1;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam int THR_MAX = 1048320;
    localparam int THR_MIN = -1048320;
    localparam int SETTLE_CYCLES = 60;
    localparam longint LIMIT_NS = 60_000_000;

    typedef struct packed {
        logic [MW-1:0]      mean;
        logic signed [MW:0] slope;
        logic               over;
        logic               beat;
        logic [TIMER_W-1:0] interval;
        logic [BPM_W-1:0]   bpm;
    } block_result_t;

    class spr_scoreboard;
        logic [COUNT_W-1:0] block_size;
        logic signed [MW:0] threshold;
        logic               invert;
        logic [TIMER_W-1:0] min_interval;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [MW-1:0]      prev_mean;
        logic [TIMER_W-1:0] timer;
        logic [TIMER_W-1:0] held_interval;
        logic [BPM_W-1:0]   held_bpm;
        block_result_t      pending[$];
        int                 errors;

        function new();
            block_size    = BLOCK_SIZE_RST;
            threshold     = (MW + 1)'(THRESHOLD_RST);
            invert        = 1'b0;
            min_interval  = MIN_INTERVAL_RST;
            sum           = '0;
            count         = '0;
            prev_mean     = '0;
            timer         = '0;
            held_interval = '0;
            held_bpm      = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_BLOCK_SIZE:   block_size   = value[COUNT_W-1:0];
                REG_THRESHOLD:    threshold    = value[MW:0];
                REG_INVERT:       invert       = value[0];
                REG_MIN_INTERVAL: min_interval = value[TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        // called for every accepted input transaction
        function void take_input(logic op, logic [SB-1:0] code);
            logic [SB-1:0]      c;
            logic [COUNT_W-1:0] size;
            longint unsigned    num;
            longint unsigned    q;
            longint             diff;
            block_result_t      r;
            if (op == OP_TICK)
            begin
                if (timer != TIMER_MAX)
                    timer = timer + 1'b1;
                return;
            end
            c = invert ? CODE_MAX - code : code;
            sum = sum + SUM_W'(c);
            count = count + 1'b1;
            size = (block_size == '0) ? COUNT_W'(1) : block_size;
            // a lowered block size closes the block as soon as the count reaches it
            if (count != '0 && count < size)
                return;
            if (count == '0)
                count = COUNT_W'(1);
            num = 64'(sum);
            num = (num << FB) + 64'(count >> 1);
            q = num / 64'(count);
            diff = longint'(q) - longint'(prev_mean);
            r.mean = q[MW-1:0];
            r.slope = diff[MW:0];
            r.over = diff > longint'(threshold);
            r.beat = 1'b0;
            if (r.over)
            begin
                if (timer >= min_interval)
                begin
                    r.beat = 1'b1;
                    held_interval = timer;
                    held_bpm = (timer == '0) ? '0 : BPM_NUMERATOR / timer;
                end
                // rejected candidates restart the timer too
                timer = '0;
            end
            r.interval = held_interval;
            r.bpm = held_bpm;
            prev_mean = q[MW-1:0];
            sum = '0;
            count = '0;
            pending.push_back(r);
        endfunction

        function void check_block(block_result_t got);
            block_result_t want;
            if (pending.size() == 0)
            begin
                $error("block result with none expected: block_mean %0d", got.mean);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mean !== want.mean)
            begin
                $error("block_mean expected %0d actual %0d", want.mean, got.mean);
                errors++;
            end
            if (got.slope !== want.slope)
            begin
                $error("slope expected %0d actual %0d", want.slope, got.slope);
                errors++;
            end
            if (got.over !== want.over)
            begin
                $error("over_threshold expected %0d actual %0d", want.over, got.over);
                errors++;
            end
            if (got.beat !== want.beat)
            begin
                $error("beat_accepted expected %0d actual %0d", want.beat, got.beat);
                errors++;
            end
            if (got.interval !== want.interval)
            begin
                $error("interval_ms expected %0d actual %0d", want.interval, got.interval);
                errors++;
            end
            if (got.bpm !== want.bpm)
            begin
                $error("bpm expected %0d actual %0d", want.bpm, got.bpm);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                operation = OP_SAMPLE;
    logic [SB-1:0]       sample_code = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [MW-1:0]       block_mean;
    logic signed [MW:0]  slope;
    logic                over_threshold;
    logic                beat_accepted;
    logic [TIMER_W-1:0]  interval_ms;
    logic [BPM_W-1:0]    bpm;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    spr_scoreboard sb = new();

    // sender and receiver idling knobs, changed per phase
    int burst_left = 0;
    int burst_max = 4;
    int gap_max = 3;
    int stall_max = 4;
    int free_max = 3;
    int run_left = 0;
    bit stalling = 1'b0;

    // slow square wave that the well-formed random samples follow
    int wave_left = 0;
    bit wave_high = 1'b0;
    logic [SB-1:0] wave_code = '0;

    block_result_t seen;

    block_slope_pulse_rate_detector DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .sample_code(sample_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .block_mean(block_mean),
        .slope(slope),
        .over_threshold(over_threshold),
        .beat_accepted(beat_accepted),
        .interval_ms(interval_ms),
        .bpm(bpm),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 clk = ~clk;

    // result checking and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen.mean = block_mean;
            seen.slope = slope;
            seen.over = over_threshold;
            seen.beat = beat_accepted;
            seen.interval = interval_ms;
            seen.bpm = bpm;
            sb.check_block(seen);
        end
        if (stall_max == 0)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (run_left <= 0)
            begin
                stalling = !stalling;
                run_left = stalling ? $urandom_range(stall_max, 1) : $urandom_range(free_max, 1);
            end
            run_left--;
            out_stall <= stalling;
        end
    end

    task automatic send(input logic op, input logic [SB-1:0] code);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(burst_max, 1);
            gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                operation <= 1'($urandom);
                sample_code <= SB'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        sample_code <= code;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.take_input(op, code);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send(OP_TICK, SB'($urandom));
    endtask

    // drop valid and wait for every expected block plus the pipeline latency
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input int bs, input int thr, input int inv, input int mi);
        drain();
        apb_write(REG_BLOCK_SIZE, bs);
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_INVERT, inv);
        apb_write(REG_MIN_INTERVAL, mi);
        @(posedge clk);
    endtask

    task automatic random_item();
        if ($urandom_range(99, 0) < 10)
        begin
            send(1'($urandom), SB'($urandom));
        end
        else if ($urandom_range(99, 0) < 45)
        begin
            send(OP_TICK, SB'($urandom));
        end
        else
        begin
            if (wave_left <= 0)
            begin
                wave_high = !wave_high;
                wave_left = $urandom_range(12, 1);
                wave_code = wave_high ? SB'($urandom_range(4095, 2048))
                                      : SB'($urandom_range(2047, 0));
            end
            wave_left--;
            send(OP_SAMPLE, wave_code ^ SB'($urandom_range(15, 0)));
        end
    endtask

    initial
    begin
        int bs;
        int thr;
        int mi;
        int sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale steps, zero interval accepted and a short interval
        configure(1, 0, 0, 0);
        send(OP_SAMPLE, '0);
        send(OP_SAMPLE, CODE_MAX);
        send(OP_SAMPLE, '0);
        send_ticks(3);
        send(OP_SAMPLE, CODE_MAX);
        send(OP_SAMPLE, CODE_MAX);

        // lowest threshold with inverted samples, candidates rejected
        configure(1, THR_MIN, 1, 65535);
        send(OP_SAMPLE, CODE_MAX);
        send(OP_SAMPLE, '0);
        send(OP_SAMPLE, 12'd2048);

        // block size zero acts as one, highest threshold never fires
        configure(0, THR_MAX, 1, 1);
        send(OP_SAMPLE, '0);
        send(OP_SAMPLE, CODE_MAX);

        // largest block size, then lowered mid-block
        configure(65535, THRESHOLD_RST, 0, MIN_INTERVAL_RST);
        send(OP_SAMPLE, CODE_MAX);
        send(OP_SAMPLE, 12'd1);
        send(OP_SAMPLE, 12'd2048);
        configure(2, THRESHOLD_RST, 0, MIN_INTERVAL_RST);
        send(OP_SAMPLE, 12'd7);

        // rounding of the mean
        configure(3, THRESHOLD_RST, 0, MIN_INTERVAL_RST);
        send(OP_SAMPLE, 12'd1);
        send(OP_SAMPLE, 12'd1);
        send(OP_SAMPLE, 12'd2);

        // beat accepted at exactly the minimum interval
        gap_max = 0;
        stall_max = 0;
        configure(1, THR_MIN, 0, 25);
        send(OP_SAMPLE, '0);
        send(OP_SAMPLE, CODE_MAX);
        send_ticks(25);
        send(OP_SAMPLE, 12'd2000);

        for (int p = 0; p < 8; p++)
        begin
            sel = $urandom_range(9, 0);
            bs = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(40, 10) : $urandom_range(6, 1);
            sel = $urandom_range(9, 0);
            thr = (sel == 0) ? THR_MIN : (sel == 1) ? THR_MAX
                : int'($urandom_range(200000, 0)) - 100000;
            sel = $urandom_range(9, 0);
            mi = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(25, 1);
            gap_max = (p == 2) ? 0 : $urandom_range(6, 0);
            burst_max = $urandom_range(20, 1);
            stall_max = (p % 3 == 0) ? 0 : $urandom_range(12, 1);
            free_max = $urandom_range(12, 1);
            configure(bs, thr, $urandom_range(1, 0), mi);
            repeat (130) random_item();
        end

        drain();
        if (sb.errors == 0)
            $display("block_slope_pulse_rate_detector_tb OK");
        else
            $display("block_slope_pulse_rate_detector_tb NOT OK");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("block_slope_pulse_rate_detector_tb NOT OK");
        $finish;
    end

endmodule
